// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define MFBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfbp assertion failed");

// next-cycle implication, held off during reset
`define MFBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfbp assertion failed");

`endif

// ===== rtl/mfbp_pkg.sv =====
// shared types, constants and width helpers of the msb-first bit packer
package mfbp_pkg;

  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int CODE_W            = 32;
  localparam int COUNT_W           = 6;
  localparam int BYTE_W            = 8;
  localparam int QUEUE_DEPTH       = 2;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  // left-aligned code register width, at least one byte
  function automatic int rem_width(input int max_bits);
    return (max_bits < BYTE_W) ? BYTE_W : max_bits;
  endfunction

  // width of a bit count in 0..max_bits
  function automatic int cnt_width(input int max_bits);
    return $clog2(max_bits + 1);
  endfunction

  // queue entry: flush flag, aligned code bits, bit count
  function automatic int entry_width(input int max_bits);
    return 1 + rem_width(max_bits) + cnt_width(max_bits);
  endfunction

endpackage

// ===== rtl/msb_first_bit_packer.sv =====
// top level of the msb-first bit packer: front, item queue and back end
// the first byte of an item, if any, is registered in the queue and then in the output register of the back end
// an append holds the back end while it emits the whole bytes that it completes,
// one byte per cycle while out_ready does not stall; a flush emits any partial byte
// the pace is set by the single byte-wide output register of the back end
// reset (rst_n low, synchronous) empties the queue and clears the partial byte
module msb_first_bit_packer #(
  parameter int MaxCodeBits = mfbp_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [mfbp_pkg::CODE_W-1:0]   in_code,
  input  logic [mfbp_pkg::COUNT_W-1:0]  in_bit_count,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mfbp_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last_of_run
);

  localparam int EntW = mfbp_pkg::entry_width(MaxCodeBits);

  // classified item: flush flag, left-aligned code bits, clamped count
  logic [EntW-1:0] fe_entry;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic [EntW-1:0] q_data;

  // front takes an item whenever the queue has a free slot
  assign in_ready = !q_full;

  mfbp_front #(
    .MaxCodeBits (MaxCodeBits)
  ) u_front (
    .in_op        (in_op),
    .in_code      (in_code),
    .in_bit_count (in_bit_count),
    .entry        (fe_entry)
  );

  // queue decouples item intake from byte output stalls
  mfbp_queue #(
    .Width (EntW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (fe_entry),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  // back end holds the partial byte and the output register
  mfbp_back #(
    .MaxCodeBits (MaxCodeBits)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== rtl/mfbp_front.sv =====
// front end: classifies an item, clamps the count and left-aligns the code bits
module mfbp_front #(
  parameter int MaxCodeBits = mfbp_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                                     in_op,
  input  logic [mfbp_pkg::CODE_W-1:0]              in_code,
  input  logic [mfbp_pkg::COUNT_W-1:0]             in_bit_count,
  output logic [mfbp_pkg::entry_width(MaxCodeBits)-1:0] entry
);

  localparam int RemW = mfbp_pkg::rem_width(MaxCodeBits);
  localparam int CntW = mfbp_pkg::cnt_width(MaxCodeBits);
  localparam int ShW  = $clog2(RemW + 1);

  logic            is_flush;
  logic [CntW-1:0] cnt;
  logic [ShW-1:0]  sh;
  logic [RemW-1:0] val;
  logic [RemW-1:0] rem;

  always_comb begin
    is_flush = (mfbp_pkg::op_t'(in_op) == mfbp_pkg::OP_FLUSH);
    if (32'(in_bit_count) > 32'(MaxCodeBits)) begin
      cnt = CntW'(MaxCodeBits);
    end else begin
      cnt = CntW'(in_bit_count);
    end
    // bits above the code width read as zero
    val = RemW'(in_code);
    sh  = ShW'(RemW) - ShW'(cnt);
    rem = is_flush ? '0 : (val << sh);
    entry = {is_flush, rem, (is_flush ? CntW'(0) : cnt)};
  end

endmodule

// ===== rtl/mfbp_queue.sv =====
// short first-in first-out queue between front and back
`include "assert_macros.svh"
module mfbp_queue #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [Width-1:0] data
);

  localparam int Depth = mfbp_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign valid   = (cnt_r != '0);
  assign data    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `MFBP_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, cnt_r <= CntW'(Depth))
  `MFBP_ASSERT_NXT(a_q_fill, clk, rst_n, do_push && !do_pop, cnt_r != '0)

endmodule

// ===== rtl/mfbp_back.sv =====
// back end: merges aligned code bits into the partial byte and emits bytes
`include "assert_macros.svh"
module mfbp_back #(
  parameter int MaxCodeBits = mfbp_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_valid,
  input  logic [mfbp_pkg::entry_width(MaxCodeBits)-1:0] q_data,
  output logic                                          q_pop,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [mfbp_pkg::BYTE_W-1:0]                   out_byte,
  output logic                                          out_last_of_run
);

  localparam int RemW = mfbp_pkg::rem_width(MaxCodeBits);
  localparam int CntW = mfbp_pkg::cnt_width(MaxCodeBits);
  localparam int AvW  = ((CntW > 4) ? CntW : 4) + 1;
  localparam int BW   = mfbp_pkg::BYTE_W;

  logic            busy_r, busy_nxt;
  logic [RemW-1:0] rem_r, rem_nxt;
  logic [CntW-1:0] rem_cnt_r, rem_cnt_nxt;
  logic [BW-1:0]   pend_r, pend_nxt;
  logic [2:0]      fill_r, fill_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [BW-1:0]   out_byte_r, out_byte_nxt;
  logic            out_last_r, out_last_nxt;

  logic            head_flush;
  logic [RemW-1:0] head_rem, cur_rem, rem_sh;
  logic [CntW-1:0] head_cnt, cur_cnt, cnt_left;
  logic            can_emit, step, fl_step, enough, last;
  logic [AvW-1:0]  avail;
  logic [3:0]      take;
  logic [BW-1:0]   merged;

  assign head_flush = q_data[RemW+CntW];
  assign head_rem   = q_data[CntW +: RemW];
  assign head_cnt   = q_data[CntW-1:0];

  always_comb begin
    can_emit = !out_valid_r || out_ready;
    cur_rem  = busy_r ? rem_r : head_rem;
    cur_cnt  = busy_r ? rem_cnt_r : head_cnt;
    step     = can_emit && (busy_r || (q_valid && !head_flush));
    fl_step  = can_emit && !busy_r && q_valid && head_flush;
    q_pop    = can_emit && !busy_r && q_valid;

    avail    = AvW'(fill_r) + AvW'(cur_cnt);
    enough   = (avail >= AvW'(BW));
    last     = (avail < AvW'(2 * BW));
    take     = 4'(BW) - 4'(fill_r);
    merged   = pend_r | (cur_rem[RemW-1 -: BW] >> fill_r);
    rem_sh   = cur_rem << take;
    cnt_left = CntW'(AvW'(cur_cnt) - AvW'(take));
  end

  always_comb begin
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    rem_cnt_nxt   = rem_cnt_r;
    pend_nxt      = pend_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (step) begin
      if (enough) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = merged;
        out_last_nxt  = last;
        if (last) begin
          // leftover bits fit in the partial byte
          busy_nxt = 1'b0;
          pend_nxt = rem_sh[RemW-1 -: BW];
          fill_nxt = 3'(cnt_left);
        end else begin
          busy_nxt    = 1'b1;
          rem_nxt     = rem_sh;
          rem_cnt_nxt = cnt_left;
          pend_nxt    = '0;
          fill_nxt    = '0;
        end
      end else begin
        busy_nxt = 1'b0;
        pend_nxt = merged;
        fill_nxt = avail[2:0];
      end
    end else if (fl_step) begin
      if (fill_r != '0) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = pend_r;
        out_last_nxt  = 1'b1;
      end
      pend_nxt = '0;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    rem_cnt_r  <= rem_cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

  `MFBP_ASSERT_IMP(a_busy_bits, clk, rst_n, busy_r, rem_cnt_r != '0)
  `MFBP_ASSERT_NXT(a_more_bytes, clk, rst_n, step && enough && !last, busy_r)
  `MFBP_ASSERT_NXT(a_flush_clears, clk, rst_n, fl_step, fill_r == '0 && pend_r == '0)

endmodule

// ===== sim/tb.sv =====
// testbench of msb_first_bit_packer: directed and random code streams against a packing model
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    logic [mfbp_pkg::BYTE_W-1:0] data;
    logic                        last;
  } packed_byte_t;

  // tracks the partial byte and the bytes still owed by the block
  class byte_stream_model;
    logic [mfbp_pkg::BYTE_W-1:0] pending_bits = '0;
    logic [2:0]                  fill_pos     = '0;
    packed_byte_t                bytes_due[$];
    int unsigned                 mismatches   = 0;

    // an item has been taken: work out the bytes it gives rise to
    function void take_item(mfbp_pkg::op_t op, logic [mfbp_pkg::CODE_W-1:0] code,
                            logic [mfbp_pkg::COUNT_W-1:0] count);
      logic [mfbp_pkg::BYTE_W-1:0] fresh[$];
      int                          n;
      if (op == mfbp_pkg::OP_FLUSH) begin
        if (fill_pos != 3'd0) fresh.push_back(pending_bits);
        pending_bits = '0;
        fill_pos     = '0;
      end else begin
        // counts above the code width are clamped
        n = (int'(count) > mfbp_pkg::MAX_CODE_BITS_DEF) ?
            mfbp_pkg::MAX_CODE_BITS_DEF : int'(count);
        for (int i = n - 1; i >= 0; i--) begin
          pending_bits[3'd7 - fill_pos] = code[i];
          if (fill_pos == 3'd7) begin
            fresh.push_back(pending_bits);
            pending_bits = '0;
            fill_pos     = '0;
          end else begin
            fill_pos = fill_pos + 3'd1;
          end
        end
      end
      foreach (fresh[k]) bytes_due.push_back('{fresh[k], k == fresh.size() - 1});
    endfunction

    function void check_byte(logic [mfbp_pkg::BYTE_W-1:0] data, logic last);
      packed_byte_t due;
      if (bytes_due.size() == 0) begin
        mismatches++;
        $display("%0t: byte %h (last %b) with nothing expected", $time, data, last);
        return;
      end
      due = bytes_due.pop_front();
      if (data !== due.data) begin
        mismatches++;
        $display("%0t: out_byte expected %h actual %h", $time, due.data, data);
      end
      if (last !== due.last) begin
        mismatches++;
        $display("%0t: out_last_of_run expected %b actual %b", $time, due.last, last);
      end
    endfunction

    function int outstanding();
      return bytes_due.size();
    endfunction
  endclass

  logic                         clk             = 1'b0;
  logic                         rst_n           = 1'b0;
  logic                         in_valid        = 1'b0;
  logic                         in_ready;
  logic                         in_op           = mfbp_pkg::OP_APPEND;
  logic [mfbp_pkg::CODE_W-1:0]  in_code         = '0;
  logic [mfbp_pkg::COUNT_W-1:0] in_bit_count    = '0;
  logic                         out_valid;
  logic                         out_ready       = 1'b0;
  logic [mfbp_pkg::BYTE_W-1:0]  out_byte;
  logic                         out_last_of_run;

  byte_stream_model sb = new;

  // idle rates in percent, changed between phases
  int unsigned send_idle = 26;
  int unsigned recv_idle = 45;

  msb_first_bit_packer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_code         (in_code),
    .in_bit_count    (in_bit_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // result side: check each byte taken, then choose whether to stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_byte(out_byte, out_last_of_run);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // offer one item, possibly after a random gap, and wait until it is taken
  task automatic drive_item(mfbp_pkg::op_t op, logic [mfbp_pkg::CODE_W-1:0] code,
                            logic [mfbp_pkg::COUNT_W-1:0] count);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_code      <= code;
    in_bit_count <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_item(op, code, count);
  endtask

  // hold the input back until every owed byte has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int items, int unsigned s_idle, int unsigned r_idle);
    mfbp_pkg::op_t                op;
    logic [mfbp_pkg::CODE_W-1:0]  code;
    logic [mfbp_pkg::COUNT_W-1:0] count;
    int unsigned                  pick;
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (items) begin
      op   = ($urandom_range(9) == 0) ? mfbp_pkg::OP_FLUSH : mfbp_pkg::OP_APPEND;
      pick = $urandom_range(99);
      if (pick < 8)       count = '0;
      else if (pick < 18) count = mfbp_pkg::COUNT_W'($urandom_range(63, 33));
      else if (pick < 30) count = mfbp_pkg::COUNT_W'(mfbp_pkg::MAX_CODE_BITS_DEF);
      else                count = mfbp_pkg::COUNT_W'($urandom_range(31, 1));
      pick = $urandom_range(19);
      if (pick == 0)      code = '0;
      else if (pick == 1) code = '1;
      else                code = $urandom;
      drive_item(op, code, count);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero count, empty flush, full-width codes, padding, clamping
    drive_item(mfbp_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd0);
    drive_item(mfbp_pkg::OP_FLUSH,  32'h0000_0000, 6'd0);
    drive_item(mfbp_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd32);
    drive_item(mfbp_pkg::OP_APPEND, 32'h0000_0000, 6'd32);
    drive_item(mfbp_pkg::OP_APPEND, 32'h0000_0005, 6'd3);
    drive_item(mfbp_pkg::OP_FLUSH,  32'hFFFF_FFFF, 6'd63);
    drive_item(mfbp_pkg::OP_APPEND, 32'h0000_007F, 6'd7);
    drive_item(mfbp_pkg::OP_APPEND, 32'h0000_0001, 6'd1);
    drive_item(mfbp_pkg::OP_APPEND, 32'hA5A5_A5A5, 6'd63);
    drive_item(mfbp_pkg::OP_APPEND, 32'h1234_5678, 6'd33);
    drive_item(mfbp_pkg::OP_APPEND, 32'h0000_0003, 6'd2);
    drive_item(mfbp_pkg::OP_APPEND, 32'hDEAD_BEEF, 6'd32);
    drive_item(mfbp_pkg::OP_FLUSH,  32'h0000_0000, 6'd0);
    drive_item(mfbp_pkg::OP_FLUSH,  32'h0000_0000, 6'd0);
    drive_item(mfbp_pkg::OP_APPEND, 32'h0000_0001, 6'd5);
    drive_item(mfbp_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd40);
    drive_item(mfbp_pkg::OP_FLUSH,  32'h0000_0000, 6'd0);
    drive_item(mfbp_pkg::OP_APPEND, 32'hFFFF_0F0F, 6'd16);
    drive_item(mfbp_pkg::OP_APPEND, 32'h0000_0001, 6'd1);
    drive_item(mfbp_pkg::OP_FLUSH,  32'h0000_0000, 6'd0);
    drive_item(mfbp_pkg::OP_APPEND, 32'h8000_0001, 6'd31);
    drive_item(mfbp_pkg::OP_FLUSH,  32'h0000_0000, 6'd0);
    drain();

    // random part under three idling patterns
    run_phase(130, 26, 45);
    drain();
    run_phase(130, 45, 26);
    run_phase(120, 0, 0);

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mfbp_pkg.sv
rtl/mfbp_front.sv
rtl/mfbp_queue.sv
rtl/mfbp_back.sv
rtl/msb_first_bit_packer.sv
sim/tb.sv
